>>> rtl/core/rmfa_pkg.sv
// ----------------------------------------------------------------------------
// rmfa_pkg
// Shared types, constants and helpers for the omega-phi-kappa rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package rmfa_pkg;

    localparam int ANGLE_WIDTH   = 16;
    localparam int FRACTION_BITS = 14;
    localparam int FIELD_WIDTH   = 16;
    localparam int CORDIC_ITERS  = 30;
    localparam int CW            = 33;   // cordic datapath width, q30 plus headroom
    localparam int TW            = 32;   // sine / cosine width, q30
    localparam int PW            = 64;   // product width
    localparam int SW            = 66;   // sum width
    localparam int CORDIC_LAT    = CORDIC_ITERS + 2;
    localparam int MATH_LAT      = 5;
    localparam int TOTAL_LAT     = CORDIC_LAT + MATH_LAT;

    localparam logic signed [CW-1:0] CORDIC_START_X = CW'(652032874);
    localparam logic signed [SW-1:0] LIMIT          = SW'(1) <<< FRACTION_BITS;

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] angle_x;
        logic signed [ANGLE_WIDTH-1:0] angle_y;
        logic signed [ANGLE_WIDTH-1:0] angle_z;
    } in_beat_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] r00;
        logic signed [FIELD_WIDTH-1:0] r01;
        logic signed [FIELD_WIDTH-1:0] r02;
        logic signed [FIELD_WIDTH-1:0] r10;
        logic signed [FIELD_WIDTH-1:0] r11;
        logic signed [FIELD_WIDTH-1:0] r12;
        logic signed [FIELD_WIDTH-1:0] r20;
        logic signed [FIELD_WIDTH-1:0] r21;
        logic signed [FIELD_WIDTH-1:0] r22;
    } out_beat_t;

    // arctangent of 2^-i in 32-bit turns
    function automatic logic signed [CW-1:0] atan_turns(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0:  v = 32'h20000000;
                1:  v = 32'h12e4051e;
                2:  v = 32'h09fb385b;
                3:  v = 32'h051111d4;
                4:  v = 32'h028b0d43;
                5:  v = 32'h0145d7e1;
                6:  v = 32'h00a2f61e;
                7:  v = 32'h00517c55;
                8:  v = 32'h0028be53;
                9:  v = 32'h00145f2f;
                10: v = 32'h000a2f98;
                11: v = 32'h000517cc;
                12: v = 32'h00028be6;
                13: v = 32'h000145f3;
                14: v = 32'h0000a2fa;
                15: v = 32'h0000517d;
                16: v = 32'h000028be;
                17: v = 32'h0000145f;
                18: v = 32'h00000a30;
                19: v = 32'h00000518;
                20: v = 32'h0000028c;
                21: v = 32'h00000146;
                22: v = 32'h000000a3;
                23: v = 32'h00000051;
                24: v = 32'h00000029;
                25: v = 32'h00000014;
                26: v = 32'h0000000a;
                27: v = 32'h00000005;
                28: v = 32'h00000003;
                29: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            atan_turns = CW'(v);
        end
    endfunction

    // right shift with round half away from zero
    function automatic logic signed [SW-1:0] round_shift(input logic signed [SW-1:0] v,
                                                         input int s);
        logic [SW-1:0] mag;
        logic [SW-1:0] half;
        logic [SW-1:0] r;
        begin
            half = SW'(1) << (s - 1);
            mag  = v[SW-1] ? SW'(-v) : SW'(v);
            r    = (mag + half) >> s;
            round_shift = v[SW-1] ? -$signed(r) : $signed(r);
        end
    endfunction

endpackage

>>> rtl/core/rotation_matrix_from_angles.sv
// ----------------------------------------------------------------------------
// rotation_matrix_from_angles
// Omega-phi-kappa photogrammetric rotation matrix from three binary angles.
// ----------------------------------------------------------------------------
// Takes one beat of three binary angles (32768 = pi) and returns one beat of
// the nine elements of the omega-phi-kappa rotation matrix in signed q1.14,
// rounded half away from zero and clamped to +-16384. One beat is accepted
// per cycle while the pipeline advances; each beat passes through the three
// parallel cordic pipes (reduction, 30 iterations, quadrant restore) and then
// the product path (two-factor product, round to q30, second products,
// sums, final round and clamp). The whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
module rotation_matrix_from_angles (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmfa_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rmfa_pkg::out_beat_t m_data
);
    import rmfa_pkg::*;

    // pipeline advance: output slot free or draining
    logic adv;
    logic [TOTAL_LAT-1:0] vld_reg;

    assign adv     = !vld_reg[TOTAL_LAT-1] || m_ready;
    // no beat taken while in reset
    assign s_ready = adv && aresetn;
    assign m_valid = vld_reg[TOTAL_LAT-1];

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], s_valid};
        end
    end

    // sine / cosine of each angle
    logic signed [TW-1:0] so, co, sp, cp, sk, ck;

    rmfa_cordic u_cordic_o (.aclk(aclk), .en(adv), .angle(s_data.angle_x),
                            .sin_o(so), .cos_o(co));
    rmfa_cordic u_cordic_p (.aclk(aclk), .en(adv), .angle(s_data.angle_y),
                            .sin_o(sp), .cos_o(cp));
    rmfa_cordic u_cordic_k (.aclk(aclk), .en(adv), .angle(s_data.angle_z),
                            .sin_o(sk), .cos_o(ck));

    // stage a: so*sp and co*sp in q60, trig values carried along
    logic signed [PW-1:0] sosp_a_reg, cosp_a_reg;
    logic signed [TW-1:0] so_a_reg, co_a_reg, sp_a_reg, cp_a_reg, sk_a_reg, ck_a_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sosp_a_reg <= PW'(so) * PW'(sp);
            cosp_a_reg <= PW'(co) * PW'(sp);
            so_a_reg   <= so;
            co_a_reg   <= co;
            sp_a_reg   <= sp;
            cp_a_reg   <= cp;
            sk_a_reg   <= sk;
            ck_a_reg   <= ck;
        end
    end

    // stage b: round the two-factor products back to q30
    logic signed [SW-1:0] sosp_r, cosp_r;
    logic signed [TW-1:0] sosp_b_reg, cosp_b_reg;
    logic signed [TW-1:0] so_b_reg, co_b_reg, sp_b_reg, cp_b_reg, sk_b_reg, ck_b_reg;

    assign sosp_r = round_shift(SW'(sosp_a_reg), 30);
    assign cosp_r = round_shift(SW'(cosp_a_reg), 30);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sosp_b_reg <= sosp_r[TW-1:0];
            cosp_b_reg <= cosp_r[TW-1:0];
            so_b_reg   <= so_a_reg;
            co_b_reg   <= co_a_reg;
            sp_b_reg   <= sp_a_reg;
            cp_b_reg   <= cp_a_reg;
            sk_b_reg   <= sk_a_reg;
            ck_b_reg   <= ck_a_reg;
        end
    end

    // stage c: every q60 product
    logic signed [PW-1:0] p_cpck_reg, p_sospck_reg, p_cosk_reg, p_sosk_reg, p_cospck_reg;
    logic signed [PW-1:0] p_cpsk_reg, p_cock_reg, p_sospsk_reg, p_cospsk_reg, p_sock_reg;
    logic signed [PW-1:0] p_socp_reg, p_cocp_reg;
    logic signed [TW-1:0] sp_c_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_cpck_reg   <= PW'(cp_b_reg)   * PW'(ck_b_reg);
            p_sospck_reg <= PW'(sosp_b_reg) * PW'(ck_b_reg);
            p_cosk_reg   <= PW'(co_b_reg)   * PW'(sk_b_reg);
            p_sosk_reg   <= PW'(so_b_reg)   * PW'(sk_b_reg);
            p_cospck_reg <= PW'(cosp_b_reg) * PW'(ck_b_reg);
            p_cpsk_reg   <= PW'(cp_b_reg)   * PW'(sk_b_reg);
            p_cock_reg   <= PW'(co_b_reg)   * PW'(ck_b_reg);
            p_sospsk_reg <= PW'(sosp_b_reg) * PW'(sk_b_reg);
            p_cospsk_reg <= PW'(cosp_b_reg) * PW'(sk_b_reg);
            p_sock_reg   <= PW'(so_b_reg)   * PW'(ck_b_reg);
            p_socp_reg   <= PW'(so_b_reg)   * PW'(cp_b_reg);
            p_cocp_reg   <= PW'(co_b_reg)   * PW'(cp_b_reg);
            sp_c_reg     <= sp_b_reg;
        end
    end

    // stage d: element sums in q60
    logic signed [SW-1:0] e_reg [0:8];

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg[0] <= SW'(p_cpck_reg);
            e_reg[1] <= SW'(p_sospck_reg) + SW'(p_cosk_reg);
            e_reg[2] <= SW'(p_sosk_reg) - SW'(p_cospck_reg);
            e_reg[3] <= -SW'(p_cpsk_reg);
            e_reg[4] <= SW'(p_cock_reg) - SW'(p_sospsk_reg);
            e_reg[5] <= SW'(p_cospsk_reg) + SW'(p_sock_reg);
            e_reg[6] <= SW'(sp_c_reg) <<< 30;
            e_reg[7] <= -SW'(p_socp_reg);
            e_reg[8] <= SW'(p_cocp_reg);
        end
    end

    // stage e: round to q1.14, clamp, output register
    logic signed [FIELD_WIDTH-1:0] f_next [0:8];
    out_beat_t                     m_data_reg;

    always_comb begin
        logic signed [SW-1:0] v;
        for (int i = 0; i < 9; i++) begin
            v = round_shift(e_reg[i], 60 - FRACTION_BITS);
            if (v > LIMIT) begin
                v = LIMIT;
            end else if (v < -LIMIT) begin
                v = -LIMIT;
            end
            f_next[i] = v[FIELD_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.r00 <= f_next[0];
            m_data_reg.r01 <= f_next[1];
            m_data_reg.r02 <= f_next[2];
            m_data_reg.r10 <= f_next[3];
            m_data_reg.r11 <= f_next[4];
            m_data_reg.r12 <= f_next[5];
            m_data_reg.r20 <= f_next[6];
            m_data_reg.r21 <= f_next[7];
            m_data_reg.r22 <= f_next[8];
        end
    end

    assign m_data = m_data_reg;

endmodule

>>> rtl/core/rmfa_cordic.sv
// ----------------------------------------------------------------------------
// rmfa_cordic
// Pipelined rotation-mode cordic: quadrant reduction, one iteration per
// stage, quadrant restore. Gives sine and cosine in q30.
// ----------------------------------------------------------------------------
module rmfa_cordic (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [rmfa_pkg::ANGLE_WIDTH-1:0] angle,
    output logic signed [rmfa_pkg::TW-1:0]          sin_o,
    output logic signed [rmfa_pkg::TW-1:0]          cos_o
);
    import rmfa_pkg::*;

    logic signed [CW-1:0] x_reg [0:CORDIC_ITERS];
    logic signed [CW-1:0] y_reg [0:CORDIC_ITERS];
    logic signed [CW-1:0] z_reg [0:CORDIC_ITERS];
    logic        [1:0]    q_reg [0:CORDIC_ITERS];
    logic signed [TW-1:0] sin_reg, cos_reg;

    logic [31:0] phase;
    logic [31:0] q_sum;
    logic [1:0]  q_next;
    logic [31:0] resid;

    // reduce to the nearest quadrant
    assign phase  = 32'(angle[ANGLE_WIDTH-1:0]) << (32 - ANGLE_WIDTH);
    assign q_sum  = phase + 32'h20000000;
    assign q_next = q_sum[31:30];
    assign resid  = phase - {q_next, 30'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= CORDIC_START_X;
            y_reg[0] <= '0;
            z_reg[0] <= CW'($signed(resid));
            q_reg[0] <= q_next;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_turns(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_turns(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant restore
    always_ff @(posedge aclk) begin
        if (en) begin
            unique case (q_reg[CORDIC_ITERS])
                2'd0: begin
                    cos_reg <= TW'(x_reg[CORDIC_ITERS]);
                    sin_reg <= TW'(y_reg[CORDIC_ITERS]);
                end
                2'd1: begin
                    cos_reg <= TW'(-y_reg[CORDIC_ITERS]);
                    sin_reg <= TW'(x_reg[CORDIC_ITERS]);
                end
                2'd2: begin
                    cos_reg <= TW'(-x_reg[CORDIC_ITERS]);
                    sin_reg <= TW'(-y_reg[CORDIC_ITERS]);
                end
                default: begin
                    cos_reg <= TW'(y_reg[CORDIC_ITERS]);
                    sin_reg <= TW'(-x_reg[CORDIC_ITERS]);
                end
            endcase
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// rotation matrix testbench
// Streams angle triples into the omega-phi-kappa matrix pipeline and checks
// every output beat against a bit-exact cordic and product predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import rmfa_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = TOTAL_LAT + 20;

    // arctangent of 2^-i in 32-bit turns
    localparam longint ATAN_TURNS [30] = '{
        32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4, 32'h028b0d43,
        32'h0145d7e1, 32'h00a2f61e, 32'h00517c55, 32'h0028be53, 32'h00145f2f,
        32'h000a2f98, 32'h000517cc, 32'h00028be6, 32'h000145f3, 32'h0000a2fa,
        32'h0000517d, 32'h000028be, 32'h0000145f, 32'h00000a30, 32'h00000518,
        32'h0000028c, 32'h00000146, 32'h000000a3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000a, 32'h00000005, 32'h00000003, 32'h00000001
    };

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    // expected matrices in arrival order
    out_beat_t matrix_q[$];
    int        mismatches = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        hold_request = 0;
    int        hold_left = 0;

    always #5 aclk = ~aclk;

    rotation_matrix_from_angles u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // shift right, round half away from zero
    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // sine and cosine in q30: quadrant fold, 30 cordic rotations, quadrant restore
    function automatic void cordic_sin_cos(input logic [15:0] angle,
                                           output longint sn, output longint cs);
        logic [31:0] phase;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy;
        phase = {angle, 16'h0};
        quad  = 2'((phase + 32'h20000000) >> 30);
        resid = phase - {quad, 30'b0};
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_TURNS[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_TURNS[i];
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
    endfunction

    // q60 to q1.14 with clamp
    function automatic logic [15:0] to_element(input longint q60);
        longint v;
        v = round_away(q60, 60 - FRACTION_BITS);
        if (v > (1 << FRACTION_BITS)) v = 1 << FRACTION_BITS;
        if (v < -(1 << FRACTION_BITS)) v = -(1 << FRACTION_BITS);
        return 16'(v);
    endfunction

    function automatic out_beat_t rotation_of(input in_beat_t a);
        out_beat_t r;
        longint so, co, sp, cp, sk, ck, sosp, cosp;
        cordic_sin_cos(a.angle_x, so, co);
        cordic_sin_cos(a.angle_y, sp, cp);
        cordic_sin_cos(a.angle_z, sk, ck);
        sosp  = round_away(so * sp, 30);
        cosp  = round_away(co * sp, 30);
        r.r00 = to_element(cp * ck);
        r.r01 = to_element(sosp * ck + co * sk);
        r.r02 = to_element(so * sk - cosp * ck);
        r.r10 = to_element(-(cp * sk));
        r.r11 = to_element(co * ck - sosp * sk);
        r.r12 = to_element(cosp * sk + so * ck);
        r.r20 = to_element(sp <<< 30);
        r.r21 = to_element(-(so * cp));
        r.r22 = to_element(co * cp);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // receiver: random stalls plus long hold-offs counted here
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checker: every output beat against the oldest expected matrix
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_beat_t want;
        string names [9];
        names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
        if (aresetn && m_valid && m_ready) begin
            if (matrix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output beat %h", m_data);
            end else begin
                want = matrix_q.pop_front();
                for (int i = 0; i < 9; i++) begin
                    // fields packed r00 first, at the top
                    if (m_data[(8 - i) * 16 +: 16] !== want[(8 - i) * 16 +: 16]) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%s mismatch: expected %0d actual %0d", names[i],
                                     $signed(want[(8 - i) * 16 +: 16]),
                                     $signed(m_data[(8 - i) * 16 +: 16]));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one angle triple per beat, optional idle gap first
    // ------------------------------------------------------------------------
    task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        in_beat_t b;
        b.angle_x = ax;
        b.angle_y = ay;
        b.angle_z = az;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        // values read right after the edge are the pre-edge ones
        do @(posedge aclk); while (!s_ready);
        matrix_q.push_back(rotation_of(b));
    endtask

    task automatic go_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // angles near multiples of an eighth turn, the rest uniform
    function automatic logic [15:0] pick_angle();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(7) * 8192 + $urandom_range(4) - 2);
        return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_special_angles();
        logic [15:0] marks [8];
        marks = '{16'h0000, 16'h4000, 16'h8000, 16'hc000,
                  16'h7fff, 16'hffff, 16'h0001, 16'h2000};
        foreach (marks[i]) send_angles(marks[i], 16'h0000, 16'h0000);
        foreach (marks[i]) send_angles(16'h0000, marks[i], 16'h0000);
        foreach (marks[i]) send_angles(16'h0000, 16'h0000, marks[i]);
        send_angles(16'h7fff, 16'h8000, 16'h7fff);
        go_idle();
    endtask

    task automatic test_random_angles(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) send_angles(pick_angle(), pick_angle(), pick_angle());
        go_idle();
    endtask

    // output held off long enough that the pipe fills and input stalls
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 300;
        repeat (100) send_angles(pick_angle(), pick_angle(), pick_angle());
        go_idle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_angles();
        test_random_angles(530, 8, 53);
        test_random_angles(530, 53, 8);
        test_output_stall();
        test_random_angles(530, 0, 0);
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/rmfa_pkg.sv
rtl/core/rmfa_cordic.sv
rtl/core/rotation_matrix_from_angles.sv
tb/sv/tb.sv
